[rtl/core/scde_pkg.sv]
// ----------------------------------------------------------------------------
// scde_pkg
// Shared types, register indexes and constants of the step cadence speed
// estimator.
// ----------------------------------------------------------------------------
package scde_pkg;

  // Payload types
  typedef logic signed [11:0] axis_t;
  typedef logic [23:0]        sumsq_t;
  typedef logic [11:0]        mag_t;
  typedef logic [12:0]        level_t;
  typedef logic [6:0]         speed_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_SENSOR_PRESENT = 3'd0;
  localparam logic [2:0] CFG_STEP_THRESHOLD = 3'd1;
  localparam logic [2:0] CFG_REARM_THRESH   = 3'd2;
  localparam logic [2:0] CFG_MIN_STEP_INT   = 3'd3;
  localparam logic [2:0] CFG_STOP_INTERVAL  = 3'd4;

  localparam int CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic        RST_SENSOR_PRESENT = 1'b1;
  localparam logic [11:0] RST_STEP_THRESHOLD = 12'd120;
  localparam logic [11:0] RST_REARM_THRESH   = 12'd60;
  localparam logic [15:0] RST_MIN_STEP_INT   = 16'd250;
  localparam logic [15:0] RST_STOP_INTERVAL  = 16'd2000;

  // Shared root/divide unit modes
  localparam logic RD_SQRT = 1'b0;
  localparam logic RD_DIV  = 1'b1;

  localparam int SQRT_STEPS = 12;
  localparam int DIV_STEPS  = 15;

  // Speed arithmetic
  localparam logic [14:0] SPEED_SCALE = 15'd18000;
  localparam speed_t      SPEED_LIMIT = 7'd99;
  // Any interval up to this gives an instant speed of at least the limit
  localparam logic [31:0] FAST_SINCE  = 32'd181;
  // x / 5 == (x * 205) >> 10 for x < 1024
  localparam logic [16:0] DIV5_MUL    = 17'd205;
  localparam int          DIV5_SHIFT  = 10;
  localparam int          LEVEL_SHIFT = 5;

  // Shared unit control and status
  typedef struct packed {
    logic start;
    logic mode;
  } rd_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

endpackage

[rtl/core/scde_sumsq.sv]
// ----------------------------------------------------------------------------
// scde_sumsq
// Sum of squares of the three axes, one axis at a time through one multiplier.
// ----------------------------------------------------------------------------
module scde_sumsq import scde_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  axis_t  axis_x,
  input  axis_t  axis_y,
  input  axis_t  axis_z,
  output sumsq_t sum,
  output logic   done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  sumsq_t      acc_r, acc_nxt;
  axis_t       sel;
  logic signed [23:0] prod;

  // Axis select for the shared multiplier
  always_comb begin
    case (cnt_r)
      2'd0:    sel = axis_x;
      2'd1:    sel = axis_y;
      default: sel = axis_z;
    endcase
  end

  assign prod = sel * sel;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = acc_r + {1'b0, prod[22:0]};
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign sum  = acc_r;
  assign done = done_r;

endmodule

[rtl/core/scde_rootdiv.sv]
// ----------------------------------------------------------------------------
// scde_rootdiv
// Shared restoring unit: one compare/subtract a cycle, used for the integer
// square root and for the speed division.
// ----------------------------------------------------------------------------
module scde_rootdiv import scde_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  rd_ctrl_t    ctrl,
  input  logic [23:0] src,
  input  logic [15:0] divisor,
  output rd_stat_t    stat,
  output logic [14:0] quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        mode_r, mode_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [23:0] src_r, src_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [14:0] q_r, q_nxt;
  logic [16:0] shifted, trial, remdiff;
  logic        ge;

  // One restoring step: bring in the next digit, try the subtract
  always_comb begin
    if (mode_r == RD_SQRT) begin
      shifted = {rem_r[14:0], src_r[23:22]};
      trial   = {3'b000, q_r[11:0], 2'b01};
    end else begin
      shifted = {rem_r[15:0], src_r[23]};
      trial   = {1'b0, dvs_r};
    end
    ge      = (shifted >= trial);
    remdiff = shifted - trial;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    src_nxt  = src_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      mode_nxt = ctrl.mode;
      cnt_nxt  = (ctrl.mode == RD_SQRT) ? 4'(SQRT_STEPS - 1) : 4'(DIV_STEPS - 1);
      src_nxt  = src;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? remdiff : shifted;
      q_nxt   = {q_r[13:0], ge};
      src_nxt = (mode_r == RD_SQRT) ? {src_r[21:0], 2'b00} : {src_r[22:0], 1'b0};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mode_r <= mode_nxt;
    src_r  <= src_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

[rtl/core/step_cadence_speed_estimator_top.sv]
// ----------------------------------------------------------------------------
// step_cadence_speed_estimator_top
// Accelerometer magnitude, gravity tracking, step detection and smoothed
// running speed, one request at a time under a small sequencer.
// ----------------------------------------------------------------------------
// Requests: one at a time; the next request is taken once the sequencer
//   is idle again, also while the last result still waits for out_ready.
// Reset (synchronous, rst_n low) restores the registers to defaults and
//   clears all tracking state.
module step_cadence_speed_estimator_top import scde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  axis_t                 in_accel_x,
  input  axis_t                 in_accel_y,
  input  axis_t                 in_accel_z,
  input  logic [31:0]           in_tick_ms,
  input  logic                  in_sample_valid,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output speed_t                out_speed
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQR   = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_BLEND = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // Configuration registers
  logic        sensor_present_r;
  logic [11:0] step_thr_r;
  logic [11:0] rearm_thr_r;
  logic [15:0] min_int_r;
  logic [15:0] stop_int_r;

  // Sequencer and request registers
  logic [2:0]  state_r, state_nxt;
  axis_t       ax_r, ax_nxt, ay_r, ay_nxt, az_r, az_nxt;
  logic [31:0] tick_r, tick_nxt;
  mag_t        mag_r, mag_nxt;
  speed_t      inst_r, inst_nxt;
  logic        res_zero_r, res_zero_nxt;
  logic        zero_fin_r, zero_fin_nxt;

  // Tracking state
  level_t      grav_r, grav_nxt;
  logic [31:0] last_r, last_nxt;
  speed_t      speed_r, speed_nxt;
  logic        seeded_r, seeded_nxt;
  logic        above_r, above_nxt;
  logic        first_r, first_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  speed_t      out_speed_r, out_speed_nxt;

  // Sub-unit links
  logic        sq_start, sq_done;
  sumsq_t      sq_sum;
  rd_ctrl_t    rd_ctrl;
  rd_stat_t    rd_stat;
  logic [14:0] rd_quot;

  // Update arithmetic
  logic signed [13:0] diff, adj, lvl_step, grav_sum;
  logic [13:0] motion;
  logic [31:0] since;
  logic        step_hit, rearm_hit;
  logic [8:0]  bsum;
  logic [16:0] bprod;
  speed_t      blended;
  logic        accept, go;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign go       = sensor_present_r && in_sample_valid;
  assign sq_start = accept && go;

  scde_sumsq u_sumsq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .axis_x (ax_r),
    .axis_y (ay_r),
    .axis_z (az_r),
    .sum    (sq_sum),
    .done   (sq_done)
  );

  // Root starts when the sum is ready; divide when the update asks for it
  always_comb begin
    rd_ctrl.start = 1'b0;
    rd_ctrl.mode  = RD_SQRT;
    if (state_r == ST_SQR && sq_done) begin
      rd_ctrl.start = 1'b1;
    end else if (state_r == ST_UPD && seeded_r && step_hit && first_r &&
                 since <= {16'b0, stop_int_r} && since > FAST_SINCE) begin
      rd_ctrl.start = 1'b1;
      rd_ctrl.mode  = RD_DIV;
    end
  end

  scde_rootdiv u_rootdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (rd_ctrl),
    .src     ((rd_ctrl.mode == RD_SQRT) ? sq_sum : {SPEED_SCALE, 9'b0}),
    .divisor (since[15:0]),
    .stat    (rd_stat),
    .quot    (rd_quot)
  );

  // Baseline difference, truncated 1/32 step, motion and interval
  always_comb begin
    diff      = $signed({2'b00, mag_r}) - $signed({1'b0, grav_r});
    adj       = diff + (diff[13] ? 14'sd31 : 14'sd0);
    lvl_step  = adj >>> LEVEL_SHIFT;
    grav_sum  = $signed({1'b0, grav_r}) + lvl_step;
    motion    = diff[13] ? 14'(-diff) : diff;
    since     = tick_r - last_r;
    step_hit  = !above_r && motion >= {2'b00, step_thr_r} &&
                since >= {16'b0, min_int_r};
    rearm_hit = above_r && motion <= {2'b00, rearm_thr_r};
  end

  // Speed smoothing: (4 * speed + instant) / 5
  assign bsum    = {speed_r, 2'b00} + {2'b00, inst_r};
  assign bprod   = {8'b0, bsum} * DIV5_MUL;
  assign blended = bprod[DIV5_SHIFT +: 7];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    az_nxt        = az_r;
    tick_nxt      = tick_r;
    mag_nxt       = mag_r;
    inst_nxt      = inst_r;
    res_zero_nxt  = res_zero_r;
    zero_fin_nxt  = zero_fin_r;
    grav_nxt      = grav_r;
    last_nxt      = last_r;
    speed_nxt     = speed_r;
    seeded_nxt    = seeded_r;
    above_nxt     = above_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_speed_nxt = out_speed_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ax_nxt       = in_accel_x;
          ay_nxt       = in_accel_y;
          az_nxt       = in_accel_z;
          tick_nxt     = in_tick_ms;
          res_zero_nxt = !go;
          state_nxt    = go ? ST_SQR : ST_DONE;
        end
      end
      ST_SQR: begin
        if (sq_done) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (rd_stat.done) begin
          mag_nxt   = rd_quot[11:0];
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        state_nxt = ST_DONE;
        if (!seeded_r) begin
          // seeding sample
          grav_nxt     = {1'b0, mag_r};
          seeded_nxt   = 1'b1;
          res_zero_nxt = 1'b1;
        end else begin
          grav_nxt = grav_sum[12:0];
          if (step_hit) begin
            last_nxt     = tick_r;
            above_nxt    = 1'b1;
            zero_fin_nxt = (stop_int_r == 16'd0);
            if (!first_r) begin
              first_nxt = 1'b1;
              speed_nxt = '0;
            end else if (since <= {16'b0, stop_int_r}) begin
              inst_nxt  = SPEED_LIMIT;
              state_nxt = (since > FAST_SINCE) ? ST_DIV : ST_BLEND;
            end
          end else begin
            zero_fin_nxt = (since >= {16'b0, stop_int_r});
            if (rearm_hit) above_nxt = 1'b0;
          end
          // no blend pending: apply the stop rule now
          if (!(step_hit && first_r && since <= {16'b0, stop_int_r})) begin
            if (step_hit ? (stop_int_r == 16'd0) : (since >= {16'b0, stop_int_r}))
              speed_nxt = '0;
          end
        end
      end
      ST_DIV: begin
        if (rd_stat.done) begin
          inst_nxt  = (rd_quot > 15'(SPEED_LIMIT)) ? SPEED_LIMIT : rd_quot[6:0];
          state_nxt = ST_BLEND;
        end
      end
      ST_BLEND: begin
        speed_nxt = zero_fin_r ? '0 : blended;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = res_zero_r ? '0 : speed_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and tracking registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      grav_r           <= '0;
      last_r           <= '0;
      speed_r          <= '0;
      seeded_r         <= 1'b0;
      above_r          <= 1'b0;
      first_r          <= 1'b0;
      sensor_present_r <= RST_SENSOR_PRESENT;
      step_thr_r       <= RST_STEP_THRESHOLD;
      rearm_thr_r      <= RST_REARM_THRESH;
      min_int_r        <= RST_MIN_STEP_INT;
      stop_int_r       <= RST_STOP_INTERVAL;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      grav_r      <= grav_nxt;
      last_r      <= last_nxt;
      speed_r     <= speed_nxt;
      seeded_r    <= seeded_nxt;
      above_r     <= above_nxt;
      first_r     <= first_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SENSOR_PRESENT: sensor_present_r <= cfg_wdata[0];
          CFG_STEP_THRESHOLD: step_thr_r       <= cfg_wdata[11:0];
          CFG_REARM_THRESH:   rearm_thr_r      <= cfg_wdata[11:0];
          CFG_MIN_STEP_INT:   min_int_r        <= cfg_wdata;
          CFG_STOP_INTERVAL:  stop_int_r       <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ax_r        <= ax_nxt;
    ay_r        <= ay_nxt;
    az_r        <= az_nxt;
    tick_r      <= tick_nxt;
    mag_r       <= mag_nxt;
    inst_r      <= inst_nxt;
    res_zero_r  <= res_zero_nxt;
    zero_fin_r  <= zero_fin_nxt;
    out_speed_r <= out_speed_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_speed = out_speed_r;

  // Checks
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    speed_r <= SPEED_LIMIT)
    else $error("speed above limit");

  a_no_speed_before_step: assert property (@(posedge clk) disable iff (!rst_n)
    !first_r |-> speed_r == '0)
    else $error("speed before first step");

  a_rd_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd_ctrl.start |-> !rd_stat.busy)
    else $error("shared unit restarted while busy");

  a_sum_to_root: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQR && sq_done) |=> (state_r == ST_ROOT && rd_stat.busy))
    else $error("root not started after sum");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    grav_r <= 13'd3547)
    else $error("gravity level out of range");

endmodule

[test/step_cadence_speed_estimator_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_cadence_speed_estimator_top_test
// Self-checking bench for the step cadence speed estimator. A behavioral
// predictor tracks gravity baseline, stride detection and speed smoothing
// for every accepted request; each result is checked in order against it.
// Directed corner cases come first, then register extremes, then long runs
// of random gaits with noise, dropped reads and tick jumps, under random
// stalls on both channels.
// ----------------------------------------------------------------------------
module step_cadence_speed_estimator_top_test import scde_pkg::*; ();

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [2:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  axis_t                 in_accel_x;
  axis_t                 in_accel_y;
  axis_t                 in_accel_z;
  logic [31:0]           in_tick_ms;
  logic                  in_sample_valid;
  logic                  out_valid;
  logic                  out_ready;
  speed_t                out_speed;

  step_cadence_speed_estimator_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_accel_x      (in_accel_x),
    .in_accel_y      (in_accel_y),
    .in_accel_z      (in_accel_z),
    .in_tick_ms      (in_tick_ms),
    .in_sample_valid (in_sample_valid),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_speed       (out_speed)
  );

  // Cycles to let pass after the last result before touching registers
  localparam int SETTLE_CYCLES = 40;

  // Predictor copy of the registers
  logic        cfg_present   = RST_SENSOR_PRESENT;
  logic [11:0] cfg_step_thr  = RST_STEP_THRESHOLD;
  logic [11:0] cfg_rearm_thr = RST_REARM_THRESH;
  logic [15:0] cfg_min_gap   = RST_MIN_STEP_INT;
  logic [15:0] cfg_stop_ms   = RST_STOP_INTERVAL;

  // Predictor tracking state
  int          grav_level     = 0;
  logic [31:0] last_stride_ms = '0;
  int          cur_speed      = 0;
  logic        grav_seeded    = 1'b0;
  logic        in_stride      = 1'b0;
  logic        stride_seen    = 1'b0;

  speed_t      expected_speed_q[$];
  int          mismatches   = 0;
  int          items_sent   = 0;
  logic        eager_sender = 1'b0;
  logic [31:0] clock_ms     = '0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Floor square root, one result bit per pass
  function automatic int unsigned root_floor(int unsigned v);
    int unsigned r;
    int unsigned t;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic axis_t to_axis(int v);
    if (v > 2047) return axis_t'(2047);
    if (v < -2048) return axis_t'(-2048);
    return axis_t'(v);
  endfunction

  // Expected speed for one request; advances the tracking state
  function automatic speed_t predict_speed(axis_t ax, axis_t ay, axis_t az,
                                           logic [31:0] tick, logic ok);
    int          xi, yi, zi, diff, motion, inst;
    int unsigned mag;
    logic [31:0] since;
    if (!cfg_present || !ok) return '0;
    xi = ax;
    yi = ay;
    zi = az;
    mag = root_floor(xi * xi + yi * yi + zi * zi);
    // first good read only seeds the baseline
    if (!grav_seeded) begin
      grav_level  = mag;
      grav_seeded = 1'b1;
      return '0;
    end
    diff = int'(mag) - grav_level;
    grav_level += diff / 32;
    motion = (diff < 0) ? -diff : diff;
    since = tick - last_stride_ms;
    if (!in_stride && motion >= int'(cfg_step_thr) && since >= 32'(cfg_min_gap)) begin
      if (stride_seen) begin
        if (since <= 32'(cfg_stop_ms)) begin
          inst = (since == 0) ? int'(SPEED_LIMIT) : int'(32'(SPEED_SCALE) / since);
          if (inst > int'(SPEED_LIMIT)) inst = int'(SPEED_LIMIT);
          cur_speed = (cur_speed * 4 + inst) / 5;
        end
      end else begin
        stride_seen = 1'b1;
        cur_speed   = 0;
      end
      last_stride_ms = tick;
      in_stride      = 1'b1;
    end else if (in_stride && motion <= int'(cfg_rearm_thr)) begin
      in_stride = 1'b0;
    end
    // speed drops out after too long without a stride
    if (tick - last_stride_ms >= 32'(cfg_stop_ms)) cur_speed = 0;
    return speed_t'(cur_speed);
  endfunction

  // Sender gap: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (eager_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Result side stalls
  initial begin
    int hold;
    int r;
    out_ready = 1'b1;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready = 1'b1;
          hold = $urandom_range(0, 30);
        end else if (r < 94) begin
          out_ready = 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ready = 1'b0;
          hold = $urandom_range(10, 60);
        end
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : speed_checker
    speed_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_speed_q.size() == 0) begin
        $error("unexpected result: speed %0d", out_speed);
        mismatches++;
      end else begin
        want = expected_speed_q.pop_front();
        if (out_speed !== want) begin
          $error("speed mismatch: expected %0d, actual %0d", want, out_speed);
          mismatches++;
        end
      end
    end
  end

  // One request; returns at the falling edge after it is taken
  task automatic send_sample(input axis_t ax, input axis_t ay, input axis_t az,
                             input logic [31:0] tick, input logic ok);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_accel_x      = ax;
    in_accel_y      = ay;
    in_accel_z      = az;
    in_tick_ms      = tick;
    in_sample_valid = ok;
    in_valid        = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_speed_q.push_back(predict_speed(ax, ay, az, tick, ok));
    items_sent++;
    @(negedge clk);
  endtask

  // Sample sitting right on the baseline: zero motion
  task automatic send_rest(input logic [31:0] tick);
    send_sample('0, '0, to_axis(grav_level), tick, 1'b1);
  endtask

  // Sample above the baseline by amp
  task automatic send_stride(input logic [31:0] tick, input int amp);
    send_sample('0, '0, to_axis(grav_level + amp), tick, 1'b1);
  endtask

  // Hold off until every result is back and the block is quiet
  task automatic settle();
    in_valid = 1'b0;
    while (expected_speed_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int val);
    settle();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_SENSOR_PRESENT: cfg_present   = val[0];
      CFG_STEP_THRESHOLD: cfg_step_thr  = val[11:0];
      CFG_REARM_THRESH:   cfg_rearm_thr = val[11:0];
      CFG_MIN_STEP_INT:   cfg_min_gap   = val[15:0];
      CFG_STOP_INTERVAL:  cfg_stop_ms   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic present, input int thr, input int rearm,
                                input int min_gap, input int stop_ms);
    write_reg(CFG_SENSOR_PRESENT, present);
    write_reg(CFG_STEP_THRESHOLD, thr);
    write_reg(CFG_REARM_THRESH, rearm);
    write_reg(CFG_MIN_STEP_INT, min_gap);
    write_reg(CFG_STOP_INTERVAL, stop_ms);
  endtask

  // Walking pattern: gravity on one axis, a stride every k samples, plus
  // noise, failed reads, junk samples and tick jumps
  task automatic run_gait(input int n);
    int axis, dir, gmag, amp, k, dt, noise, r;
    int v[3];
    axis  = $urandom_range(0, 2);
    dir   = $urandom_range(0, 1) ? 1 : -1;
    gmag  = $urandom_range(200, 1500);
    amp   = ($urandom_range(0, 9) < 8) ? $urandom_range(100, 600) : $urandom_range(0, 2047);
    k     = $urandom_range(2, 8);
    dt    = $urandom_range(15, 150);
    noise = $urandom_range(0, 20);
    eager_sender = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      clock_ms += dt + $urandom_range(0, 10);
      if (r < 8) begin
        send_sample(axis_t'($urandom), axis_t'($urandom), axis_t'($urandom), clock_ms, 1'b0);
      end else if (r < 12) begin
        send_sample(axis_t'($urandom), axis_t'($urandom), axis_t'($urandom), clock_ms, 1'b1);
      end else begin
        if (r < 14) clock_ms = $urandom;
        for (int a = 0; a < 3; a++) v[a] = int'($urandom_range(0, 2 * noise)) - noise;
        v[axis] += dir * (gmag + ((i % k == 0) ? amp : 0));
        send_sample(to_axis(v[0]), to_axis(v[1]), to_axis(v[2]), clock_ms, 1'b1);
      end
    end
    eager_sender = 1'b0;
  endtask

  // Failed read before seeding, seeding, then axis extremes
  task automatic test_seed_and_extremes();
    send_sample(axis_t'(-2048), axis_t'(2047), axis_t'(-2048), 32'd0, 1'b0);
    send_sample('0, '0, axis_t'(1000), 32'd0, 1'b1);
    send_sample(axis_t'(2047), axis_t'(2047), axis_t'(2047), 32'd10, 1'b1);
    send_sample(axis_t'(-2048), axis_t'(-2048), axis_t'(-2048), 32'd20, 1'b1);
    send_sample('0, '0, '0, 32'd30, 1'b1);
  endtask

  // Stride timing: first stride, smoothing, too-early stride, stop timeout,
  // tick wrap, backwards tick and a zero interval
  task automatic test_step_timing();
    send_stride(32'd1000, 400);
    send_rest(32'd1100);
    send_stride(32'd1400, 400);
    send_rest(32'd1500);
    send_stride(32'd1600, 400);
    send_rest(32'd1650);
    send_stride(32'd1700, 400);
    send_rest(32'd3800);
    send_stride(32'd3900, 400);
    send_rest(32'hFFFF_FF80);
    send_stride(32'hFFFF_FFC0, 400);
    send_rest(32'h0000_0010);
    send_stride(32'h0000_0100, 400);
    send_rest(32'h0000_0080);
    send_stride(32'h0000_0050, 400);
    // zero interval saturates the instant speed
    write_reg(CFG_MIN_STEP_INT, 0);
    send_rest(32'd200);
    send_stride(32'd300, 400);
    send_rest(32'd300);
    send_stride(32'd300, 400);
    write_reg(CFG_MIN_STEP_INT, RST_MIN_STEP_INT);
  endtask

  // No accelerometer: every result is zero and nothing moves
  task automatic test_sensor_absent();
    write_reg(CFG_SENSOR_PRESENT, 0);
    send_stride(32'd400, 500);
    send_sample(axis_t'(2047), axis_t'(-2048), axis_t'(2047), 32'hFFFF_FFFF, 1'b1);
    send_sample(axis_t'(-2048), axis_t'(2047), axis_t'(-2048), 32'd500, 1'b0);
    write_reg(CFG_SENSOR_PRESENT, 1);
  endtask

  // Register extremes, each under a short gait
  task automatic test_config_extremes();
    apply_settings(1'b1, 0, 0, 0, 1);
    run_gait(20);
    apply_settings(1'b1, 4095, 4095, 65535, 65535);
    run_gait(20);
    apply_settings(1'b1, 0, 4095, 0, 65535);
    run_gait(20);
    apply_settings(1'b1, 200, 100, 65535, 1);
    run_gait(20);
    apply_settings(RST_SENSOR_PRESENT, RST_STEP_THRESHOLD, RST_REARM_THRESH,
                   RST_MIN_STEP_INT, RST_STOP_INTERVAL);
  endtask

  // Random gaits under occasional random register settings
  task automatic test_random_gaits();
    int thr;
    clock_ms = $urandom;
    while (items_sent < 550) begin
      if ($urandom_range(0, 2) == 0) begin
        thr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(60, 400);
        apply_settings($urandom_range(0, 9) != 0, thr, $urandom_range(0, thr),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 400),
                       ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535)
                                                   : $urandom_range(300, 3000));
      end
      run_gait($urandom_range(10, 50));
    end
  endtask

  // Main sequence
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_SENSOR_PRESENT;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_accel_x      = '0;
    in_accel_y      = '0;
    in_accel_z      = '0;
    in_tick_ms      = '0;
    in_sample_valid = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_seed_and_extremes();
    test_step_timing();
    test_sensor_absent();
    test_config_extremes();
    test_random_gaits();

    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
